/* rtl/lcc_pkg.sv */
`default_nettype none
package lcc_pkg;

    localparam int ENTRIES  = 8;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int STAMP_W  = 64;
    localparam int CFG_W    = 4;
    localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SLOT_W   = 3;
    localparam int EVK_W    = 32;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int ADDR_W   = 3;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(8);

    // Register index, taken from the word address
    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 2'd0,
        ST_FREE   = 2'd1,
        ST_EVICT  = 2'd2,
        ST_PINNED = 2'd3
    } status_t;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } lcc_cmd_t;

    typedef struct packed {
        logic hit_now;
        logic last;
    } lcc_stat_t;

endpackage
`default_nettype wire

/* rtl/lcc_datapath.sv */
`default_nettype none
module lcc_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lcc_pkg::lcc_cmd_t             cmd,
    output lcc_pkg::lcc_stat_t                 stat,
    input  wire logic                          in_pin,
    input  wire logic [lcc_pkg::KEY_W-1:0]     in_key,
    input  wire logic [lcc_pkg::CFG_W-1:0]     cfg_max_entries,
    output lcc_pkg::status_t                   out_status,
    output logic [lcc_pkg::SLOT_W-1:0]         out_slot,
    output logic [lcc_pkg::EVK_W-1:0]          out_evicted_key
);
    import lcc_pkg::*;

    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  pinned_reg;
    logic [KEY_BITS-1:0] key_mem   [ENTRIES];
    logic [STAMP_W-1:0]  stamp_mem [ENTRIES];
    logic [STAMP_W-1:0]  tick_reg;

    logic [KEY_BITS-1:0] req_key_reg;
    logic                req_pin_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [CNT_W-1:0]    used_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                vic_found_reg;
    logic [IDX_W-1:0]    vic_idx_reg;
    logic [STAMP_W-1:0]  vic_stamp_reg;
    logic [KEY_BITS-1:0] vic_key_reg;

    status_t             out_status_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [EVK_W-1:0]    out_evk_reg;

    logic                cur_valid;
    logic                cur_pinned;
    logic [KEY_BITS-1:0] cur_key;
    logic [STAMP_W-1:0]  cur_stamp;
    logic                cur_hit;
    logic                vic_upd;
    logic [LIM_W-1:0]    limit;
    logic                full;
    status_t             res_status;
    logic [IDX_W-1:0]    res_idx;
    logic                do_write;
    logic [STAMP_W-1:0]  tick_next;

    assign cur_valid  = valid_reg[idx_reg];
    assign cur_pinned = pinned_reg[idx_reg];
    assign cur_key    = key_mem[idx_reg];
    assign cur_stamp  = stamp_mem[idx_reg];
    assign cur_hit    = cur_valid && (cur_key == req_key_reg);
    assign vic_upd    = cmd.step && cur_valid && !cur_pinned &&
                        (!vic_found_reg || (cur_stamp < vic_stamp_reg));

    assign stat.hit_now = cur_hit;
    assign stat.last    = (idx_reg == IDX_W'(ENTRIES - 1));

    // Clamp the limit to 1..ENTRIES
    always_comb begin
        if (cfg_max_entries == '0) begin
            limit = LIM_W'(1);
        end else if (LIM_W'(cfg_max_entries) > LIM_W'(ENTRIES)) begin
            limit = LIM_W'(ENTRIES);
        end else begin
            limit = LIM_W'(cfg_max_entries);
        end
    end

    assign full = (LIM_W'(used_reg) >= limit) || !free_found_reg;

    always_comb begin
        priority if (hit_reg) begin
            res_status = ST_HIT;
            res_idx    = hit_idx_reg;
        end else if (full && !vic_found_reg) begin
            res_status = ST_PINNED;
            res_idx    = '0;
        end else if (full) begin
            res_status = ST_EVICT;
            res_idx    = vic_idx_reg;
        end else begin
            res_status = ST_FREE;
            res_idx    = free_idx_reg;
        end
    end

    assign do_write  = cmd.commit && (res_status != ST_PINNED);
    assign tick_next = tick_reg + STAMP_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            pinned_reg     <= '0;
            tick_reg       <= '0;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            used_reg       <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            vic_found_reg  <= 1'b0;
            vic_idx_reg    <= '0;
        end else begin
            if (cmd.start) begin
                idx_reg        <= '0;
                hit_reg        <= 1'b0;
                used_reg       <= '0;
                free_found_reg <= 1'b0;
                vic_found_reg  <= 1'b0;
            end
            if (cmd.step) begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (cur_hit) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= idx_reg;
                end
                if (cur_valid) begin
                    used_reg <= used_reg + CNT_W'(1);
                end else if (!free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
                if (vic_upd) begin
                    vic_found_reg <= 1'b1;
                    vic_idx_reg   <= idx_reg;
                end
            end
            if (do_write) begin
                tick_reg <= tick_next;
                if (res_status == ST_HIT) begin
                    pinned_reg[res_idx] <= pinned_reg[res_idx] | req_pin_reg;
                end else begin
                    valid_reg[res_idx]  <= 1'b1;
                    pinned_reg[res_idx] <= req_pin_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_key_reg <= KEY_BITS'(in_key);
            req_pin_reg <= in_pin;
        end
        if (vic_upd) begin
            vic_stamp_reg <= cur_stamp;
            vic_key_reg   <= cur_key;
        end
        if (do_write) begin
            stamp_mem[res_idx] <= tick_next;
            if (res_status != ST_HIT) begin
                key_mem[res_idx] <= req_key_reg;
            end
        end
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_idx_reg    <= res_idx;
            out_evk_reg    <= (res_status == ST_EVICT) ? EVK_W'(vic_key_reg) : '0;
        end
    end

    assign out_status      = out_status_reg;
    assign out_slot        = SLOT_W'(out_idx_reg);
    assign out_evicted_key = out_evk_reg;

    // A stored request leaves its slot valid
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (out_status_reg == ST_PINNED) || valid_reg[out_idx_reg])
        else $error("committed slot not valid");

    // The all-pinned case leaves the tick untouched
    a_err_no_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (res_status == ST_PINNED) |=> $stable(tick_reg))
        else $error("tick moved on error");

endmodule
`default_nettype wire

/* rtl/lcc_ctrl.sv */
`default_nettype none
module lcc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output lcc_pkg::lcc_cmd_t        cmd,
    input  wire lcc_pkg::lcc_stat_t  stat
);
    import lcc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.start  = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.step   = (state_reg == S_SCAN);
    // Hold the commit until the result register is free
    assign cmd.commit = (state_reg == S_COMMIT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid   = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (stat.hit_now || stat.last) begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (cmd.commit) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("result not presented after commit");

    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == S_SCAN))
        else $error("scan did not begin");

    a_hit_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && stat.hit_now |=> (state_reg == S_COMMIT))
        else $error("scan ran past a hit");

endmodule
`default_nettype wire

/* rtl/lru_context_cache_with_pinning.sv */
`default_nettype none
// Fully associative context table with LRU replacement and pinned entries.
// Request channel (s_*): tdata carries the 32-bit key, tuser[0] asks to pin
// the entry as well. Result channel (m_*): tuser carries the status (hit,
// free-slot insert, insert after eviction, all-pinned error), tdata the slot
// and the evicted key.
// One request is handled at a time. After a transfer the table is scanned
// one entry per cycle, stopping at the first key match; the commit state then
// updates the table and loads the result register once that register is
// free. A new request is taken in the cycle after the commit.
// A stalled result register holds the commit of the next request; the
// request side keeps accepting one item meanwhile.
// Reset empties the table, clears all pins and the use tick, and sets
// max_entries to 8, which lies at byte address 0 of the APB port. The user
// must write it only while no request is in flight; this is not enforced.
module lru_context_cache_with_pinning (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lcc_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] key
    input  wire logic                              s_tuser,   // [0] req_type
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lcc_pkg::OUT_DATA_W-1:0]         m_tdata,   // [2:0] slot, [34:3] evicted_key
    output logic [lcc_pkg::STATUS_W-1:0]           m_tuser,   // [1:0] status
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lcc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import lcc_pkg::*;

    lcc_cmd_t           cmd;
    lcc_stat_t          stat;
    logic [CFG_W-1:0]   max_entries_reg;
    logic               reg_idx;
    status_t            out_status;
    logic [SLOT_W-1:0]  out_slot;
    logic [EVK_W-1:0]   out_evk;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready && (reg_idx == REG_MAX_ENTRIES)) begin
            max_entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_MAX_ENTRIES) ? 32'(max_entries_reg) : '0;

    lcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lcc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_pin          (s_tuser),
        .in_key          (s_tdata[KEY_W-1:0]),
        .cfg_max_entries (max_entries_reg),
        .out_status      (out_status),
        .out_slot        (out_slot),
        .out_evicted_key (out_evk)
    );

    assign m_tuser = out_status;
    assign m_tdata = {(OUT_DATA_W - SLOT_W - EVK_W)'(0), out_evk, out_slot};

endmodule
`default_nettype wire
